@@ rtl/fbct_pkg.sv @@
// Package with the request and result types and the register map of the frustum cull test.
`timescale 1ns / 1ps

package fbct_pkg;

  localparam int unsigned NumPlanes  = 6;
  localparam int unsigned CoordW     = 24;
  localparam int unsigned NormW      = 13;
  localparam int unsigned PlaneW     = 63;
  localparam int unsigned MarginW    = 8;
  localparam int unsigned TagW       = 64;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 63;
  // Scale of the doubled offset and margin from Q.8 into the Q.20 product domain.
  localparam int unsigned FracShift  = 13;
  localparam logic [MarginW-1:0] MarginReset = 8'd3;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegPlaneLeft   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPlaneRight  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPlaneBottom = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPlaneTop    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPlaneNear   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPlaneFar    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCullMargin  = 3'd6;

  typedef struct packed {
    logic [TagW-1:0]          tag;
    logic                     bounds_valid;
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
  } fbct_req_t;

  typedef struct packed {
    logic [TagW-1:0] tag_out;
    logic            visible;
  } fbct_res_t;

endpackage

@@ rtl/frustum_box_cull_test.sv @@
// Top level of the frustum cull test: six-plane box visibility in a five-stage pipeline.
`timescale 1ns / 1ps

// Channel    Direction  Signals                          Meaning
// request    in         start, busy, req_i               one box with tag and valid flag
// result     out        done_o, res_o                    tag and visible flag, one cycle
// config     in         cfg_we_i, cfg_idx_i, cfg_wdata_i six planes and the cull margin
//
// A request is taken at every rising edge with start high; busy is always low, so one box
// enters per clock. Its result appears on done_o for exactly one cycle.
// The latency is set by the five register stages: corner sum and difference, the products,
// two levels of the per-plane adder tree with the compare, and the result register.
// Reset clears the valid bits of all stages, the planes to zero and the margin to three.
// The receiver cannot stall, so the pipeline never stops and no request waits.
module frustum_box_cull_test
  import fbct_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  fbct_req_t           req_i,
  output logic                done_o,
  output fbct_res_t           res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned SumW  = CoordW + 1;   // c2 and e2
  localparam int unsigned ProdW = 38;           // 13 x 25 signed product
  localparam int unsigned AccW  = 42;           // per-plane sum, exact

  // Configuration registers. The user must change them only while the pipeline is empty; the block does not enforce it.
  logic [PlaneW-1:0]  plane_q [NumPlanes];
  logic [MarginW-1:0] margin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NumPlanes; p++) begin
        plane_q[p] <= '0;
      end
      margin_q <= MarginReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPlaneLeft:   plane_q[0] <= cfg_wdata_i[PlaneW-1:0];
        RegPlaneRight:  plane_q[1] <= cfg_wdata_i[PlaneW-1:0];
        RegPlaneBottom: plane_q[2] <= cfg_wdata_i[PlaneW-1:0];
        RegPlaneTop:    plane_q[3] <= cfg_wdata_i[PlaneW-1:0];
        RegPlaneNear:   plane_q[4] <= cfg_wdata_i[PlaneW-1:0];
        RegPlaneFar:    plane_q[5] <= cfg_wdata_i[PlaneW-1:0];
        RegCullMargin:  margin_q   <= cfg_wdata_i[MarginW-1:0];
        default: ;
      endcase
    end
  end

  // Plane fields: three Q1.12 normal parts, their magnitudes, and the Q16.8 offset.
  logic signed [NormW-1:0]  nrm   [NumPlanes][3];
  logic signed [NormW:0]    nabs  [NumPlanes][3];
  logic signed [CoordW-1:0] offs  [NumPlanes];

  always_comb begin
    for (int p = 0; p < NumPlanes; p++) begin
      for (int k = 0; k < 3; k++) begin
        nrm[p][k]  = plane_q[p][NormW*k +: NormW];
        nabs[p][k] = nrm[p][k][NormW-1] ? -(14'(nrm[p][k])) : 14'(nrm[p][k]);
      end
      offs[p] = plane_q[p][3*NormW +: CoordW];
    end
  end

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Stage 1: doubled center and doubled extent per axis.
  logic                   s1_vld_q, s1_bv_q;
  logic [TagW-1:0]        s1_tag_q;
  logic signed [SumW-1:0] s1_c2_q [3];
  logic signed [SumW-1:0] s1_e2_q [3];
  logic signed [SumW-1:0] s1_c2_d [3];
  logic signed [SumW-1:0] s1_e2_d [3];

  always_comb begin
    s1_c2_d[0] = SumW'(req_i.min_x) + SumW'(req_i.max_x);
    s1_e2_d[0] = SumW'(req_i.max_x) - SumW'(req_i.min_x);
    s1_c2_d[1] = SumW'(req_i.min_y) + SumW'(req_i.max_y);
    s1_e2_d[1] = SumW'(req_i.max_y) - SumW'(req_i.min_y);
    s1_c2_d[2] = SumW'(req_i.min_z) + SumW'(req_i.max_z);
    s1_e2_d[2] = SumW'(req_i.max_z) - SumW'(req_i.min_z);
  end

  // Stage 2: center and extent products for every plane and axis.
  logic                    s2_vld_q, s2_bv_q;
  logic [TagW-1:0]         s2_tag_q;
  logic signed [ProdW-1:0] s2_pc_q [NumPlanes][3];
  logic signed [ProdW-1:0] s2_pe_q [NumPlanes][3];

  // Stage 3: first adder level per plane.
  logic                   s3_vld_q, s3_bv_q;
  logic [TagW-1:0]        s3_tag_q;
  logic signed [AccW-1:0] s3_a_q [NumPlanes];
  logic signed [AccW-1:0] s3_b_q [NumPlanes];
  logic signed [AccW-1:0] s3_a_d [NumPlanes];
  logic signed [AccW-1:0] s3_b_d [NumPlanes];

  always_comb begin
    for (int p = 0; p < NumPlanes; p++) begin
      s3_a_d[p] = AccW'(s2_pc_q[p][0]) + AccW'(s2_pe_q[p][0])
                + AccW'(s2_pc_q[p][1]) + AccW'(s2_pe_q[p][1]);
      s3_b_d[p] = AccW'(s2_pc_q[p][2]) + AccW'(s2_pe_q[p][2])
                + (AccW'(offs[p]) <<< FracShift);
    end
  end

  // Stage 4: final plane sum compared against minus twice the margin.
  logic                   s4_vld_q, s4_bv_q;
  logic [TagW-1:0]        s4_tag_q;
  logic [NumPlanes-1:0]   s4_out_q;
  logic [NumPlanes-1:0]   s4_out_d;
  logic signed [AccW-1:0] limit;
  logic signed [AccW-1:0] plane_sum [NumPlanes];

  always_comb begin
    limit = -($signed(AccW'(margin_q)) <<< FracShift);
    for (int p = 0; p < NumPlanes; p++) begin
      plane_sum[p] = s3_a_q[p] + s3_b_q[p];
      s4_out_d[p]  = plane_sum[p] < limit;
    end
  end

  // Valid bits of every stage and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      done_o   <= 1'b0;
    end else begin
      s1_vld_q <= start;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      done_o   <= s4_vld_q;
    end
  end

  // Payload registers move every cycle; the valid bits say which hold a request.
  always_ff @(posedge clk_i) begin
    s1_tag_q <= req_i.tag;
    s1_bv_q  <= req_i.bounds_valid;
    s1_c2_q  <= s1_c2_d;
    s1_e2_q  <= s1_e2_d;

    s2_tag_q <= s1_tag_q;
    s2_bv_q  <= s1_bv_q;
    for (int p = 0; p < NumPlanes; p++) begin
      for (int k = 0; k < 3; k++) begin
        s2_pc_q[p][k] <= nrm[p][k] * s1_c2_q[k];
        s2_pe_q[p][k] <= nabs[p][k] * s1_e2_q[k];
      end
    end

    s3_tag_q <= s2_tag_q;
    s3_bv_q  <= s2_bv_q;
    s3_a_q   <= s3_a_d;
    s3_b_q   <= s3_b_d;

    s4_tag_q <= s3_tag_q;
    s4_bv_q  <= s3_bv_q;
    s4_out_q <= s4_out_d;

    // A box without valid bounds is always visible; otherwise any plane outside culls it.
    res_o.tag_out <= s4_tag_q;
    res_o.visible <= !s4_bv_q || !(|s4_out_q);
  end

endmodule
